@@ src/gnb_pkg.sv @@
// gnb_pkg: shared types, constants and the intensity ramp of the glyph blitter
// depends on nothing; imported by every module of the block
package gnb_pkg;

    localparam int CNT_W     = 5;   // column and row counter width
    localparam int DIM_W     = CNT_W + 1;
    localparam int OX_W      = 10;
    localparam int OY_W      = 10;
    localparam int BL_W      = 4;
    localparam int SW_W      = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int PIX_W     = 21;  // width of the framebuffer index port
    localparam int COLOR_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;

    localparam int ROW_BIAS  = 11;  // cell rows sit eleven lines above the baseline

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // reset values of the configuration registers
    localparam logic [DIM_W-2:0] RST_WIDTH    = 5'd16;
    localparam logic [DIM_W-2:0] RST_HEIGHT   = 5'd16;
    localparam logic [BL_W-1:0]  RST_BASELINE = 4'd11;
    localparam logic [SW_W-1:0]  RST_SCREEN_W = 11'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X       = 3'd0,
        REG_ORIGIN_Y       = 3'd1,
        REG_GLYPH_WIDTH    = 3'd2,
        REG_GLYPH_HEIGHT   = 3'd3,
        REG_GLYPH_BASELINE = 3'd4,
        REG_SCREEN_WIDTH   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        PH_HIGH = 1'b0,
        PH_LOW  = 1'b1
    } phase_t;

    // one classified texture byte, as the front hands it to the back
    typedef struct packed {
        logic [BYTE_W-1:0] tex_byte;
        logic [CNT_W-1:0]  col;       // column of the high nibble
        logic              two;       // both nibbles are drawn
        logic              done;      // this byte holds the glyph's final pixel
    } entry_t;

    function automatic logic [COLOR_W-1:0] gray_ramp(input logic [NIB_W-1:0] nib);
        logic [COLOR_W-1:0] c;
        case (nib)
            4'h0:    c = 16'h0001;
            4'h1:    c = 16'h1085;
            4'h2:    c = 16'h2109;
            4'h3:    c = 16'h318D;
            4'h4:    c = 16'h4211;
            4'h5:    c = 16'h5295;
            4'h6:    c = 16'h6319;
            4'h7:    c = 16'h739D;
            4'h8:    c = 16'h8C63;
            4'h9:    c = 16'h9CE7;
            4'hA:    c = 16'hAD6B;
            4'hB:    c = 16'hBDEF;
            4'hC:    c = 16'hCE73;
            4'hD:    c = 16'hDEF7;
            4'hE:    c = 16'hEF7B;
            default: c = 16'hFFFF;
        endcase
        return c;
    endfunction

endpackage

@@ src/gnb_front.sv @@
// gnb_front: takes texture bytes, walks the glyph's column and row counters
// and classifies each byte into one or two pixels; uses gnb_pkg
module gnb_front #(
    parameter int MAX_GLYPH  = 16,
    parameter int INDEX_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [gnb_pkg::BYTE_W-1:0]    tex_byte,
    input  logic                          q_full,
    input  logic [gnb_pkg::DIM_W-2:0]     glyph_width,
    input  logic [gnb_pkg::DIM_W-2:0]     glyph_height,
    input  logic [gnb_pkg::SW_W-1:0]      screen_width,
    output logic                          q_push,
    output gnb_pkg::entry_t               q_entry,
    output logic [INDEX_BITS-1:0]         q_base
);
    import gnb_pkg::*;

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_GLYPH);

    logic [CNT_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic [INDEX_BITS-1:0] base_reg, base_next;

    logic [DIM_W-1:0]      w, h;
    logic [CNT_W-1:0]      col_a, row_a;
    logic [INDEX_BITS-1:0] base_a;
    logic [CNT_W-1:0]      col_b, row_b;
    logic [INDEX_BITS-1:0] base_b;
    logic [DIM_W-1:0]      row_inc_a, row_inc_b, col_c;
    logic [INDEX_BITS-1:0] sw1, sw2, base_p1, base_p2;
    logic                  wrap_a, two, done;

    always_comb
    begin
        if (glyph_width == '0)
            w = DIM_W'(1);
        else if ({1'b0, glyph_width} > MAX_DIM)
            w = MAX_DIM;
        else
            w = {1'b0, glyph_width};
        if (glyph_height == '0)
            h = DIM_W'(1);
        else if ({1'b0, glyph_height} > MAX_DIM)
            h = MAX_DIM;
        else
            h = {1'b0, glyph_height};
    end

    assign q_push = push && !q_full;

    always_comb
    begin
        sw1 = INDEX_BITS'(screen_width);
        sw2 = sw1 << 1;

        // row count past the height restarts the glyph
        if ({1'b0, row_reg} >= h)
        begin
            col_a  = '0;
            row_a  = '0;
            base_a = '0;
        end
        else
        begin
            col_a  = col_reg;
            row_a  = row_reg;
            base_a = base_reg;
        end
        base_p1 = base_a + sw1;
        base_p2 = base_a + sw2;

        // column count past the width ends the row first
        row_inc_a = {1'b0, row_a} + DIM_W'(1);
        wrap_a    = 1'b0;
        if ({1'b0, col_a} >= w)
        begin
            col_b = '0;
            if (row_inc_a >= h)
            begin
                row_b  = '0;
                base_b = '0;
                wrap_a = 1'b1;
            end
            else
            begin
                row_b  = row_inc_a[CNT_W-1:0];
                base_b = base_p1;
            end
        end
        else
        begin
            col_b  = col_a;
            row_b  = row_a;
            base_b = base_a;
        end

        two   = ({1'b0, col_b} + DIM_W'(1)) < w;
        col_c = {1'b0, col_b} + (two ? DIM_W'(2) : DIM_W'(1));

        row_inc_b = {1'b0, row_b} + DIM_W'(1);
        done      = 1'b0;
        col_next  = col_c[CNT_W-1:0];
        row_next  = row_b;
        base_next = base_b;
        if (col_c >= w)
        begin
            col_next = '0;
            if (row_inc_b >= h)
            begin
                row_next  = '0;
                base_next = '0;
                done      = 1'b1;
            end
            else
            begin
                row_next = row_inc_b[CNT_W-1:0];
                // base_b is zero, base_a or base_a plus one stride
                if (wrap_a)
                    base_next = sw1;
                else if ({1'b0, col_a} >= w)
                    base_next = base_p2;
                else
                    base_next = base_p1;
            end
        end
    end

    assign q_entry.tex_byte = tex_byte;
    assign q_entry.col      = col_b;
    assign q_entry.two      = two;
    assign q_entry.done     = done;
    assign q_base           = base_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

@@ src/gnb_queue.sv @@
// gnb_queue: short first-in first-out queue of classified bytes between
// front and back; uses gnb_pkg for its depth
module gnb_queue #(
    parameter int DATA_W = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_full,
    output logic              q_empty
);
    import gnb_pkg::*;

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/gnb_back.sv @@
// gnb_back: turns a classified byte into one or two pixel writes, one beat
// a cycle when the output register is free; uses gnb_pkg for ramp and types
module gnb_back #(
    parameter int INDEX_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  gnb_pkg::entry_t               q_entry,
    input  logic [INDEX_BITS-1:0]         q_base,
    output logic                          q_pop,
    input  logic [gnb_pkg::OX_W-1:0]      origin_x,
    input  logic [INDEX_BITS-1:0]         top_index,
    input  logic                          pop,
    output logic                          empty,
    output logic [gnb_pkg::PIX_W-1:0]     pixel_index,
    output logic [gnb_pkg::COLOR_W-1:0]   pixel_color,
    output logic                          glyph_done,
    output logic                          last
);
    import gnb_pkg::*;

    logic                  work_valid_reg;
    entry_t                work_reg;
    logic [INDEX_BITS-1:0] idx_reg, idx_load;
    phase_t                phase_reg, phase_next;

    logic                  out_valid_reg;
    logic [PIX_W-1:0]      index_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic                  done_reg, last_reg;

    logic                  out_ready, emit, fin, load;
    logic [INDEX_BITS-1:0] emit_idx;
    logic [NIB_W-1:0]      emit_nib;
    logic                  emit_last;

    assign out_ready = !out_valid_reg || pop;
    assign emit      = work_valid_reg && out_ready;
    assign load      = !q_empty && (!work_valid_reg || fin);
    assign q_pop     = load;

    assign idx_load = INDEX_BITS'(origin_x) + INDEX_BITS'(q_entry.col) + top_index + q_base;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (load)
            phase_next = PH_HIGH;
        else if (emit)
        begin
            unique case (phase_reg)
                PH_HIGH: phase_next = work_reg.two ? PH_LOW : PH_HIGH;
                PH_LOW:  phase_next = PH_HIGH;
                default: phase_next = PH_HIGH;
            endcase
        end
    end

    // beat contents for the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_HIGH:
            begin
                emit_nib  = work_reg.tex_byte[BYTE_W-1:NIB_W];
                emit_idx  = idx_reg;
                emit_last = !work_reg.two;
            end
            PH_LOW:
            begin
                emit_nib  = work_reg.tex_byte[NIB_W-1:0];
                emit_idx  = idx_reg + 1'b1;
                emit_last = 1'b1;
            end
            default:
            begin
                emit_nib  = work_reg.tex_byte[BYTE_W-1:NIB_W];
                emit_idx  = idx_reg;
                emit_last = 1'b1;
            end
        endcase
        fin = emit && emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            phase_reg      <= PH_HIGH;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                work_valid_reg <= 1'b1;
            else if (fin)
                work_valid_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= q_entry;
            idx_reg  <= idx_load;
        end
        if (emit)
        begin
            index_reg <= PIX_W'(emit_idx);
            color_reg <= gray_ramp(emit_nib);
            done_reg  <= work_reg.done && emit_last;
            last_reg  <= emit_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_index = index_reg;
    assign pixel_color = color_reg;
    assign glyph_done  = done_reg;
    assign last        = last_reg;

endmodule

@@ src/glyph_nibble_blitter_top.sv @@
// glyph_nibble_blitter_top: top level of the 4bpp glyph blitter; holds the
// configuration registers and the cell offset, joins front, queue and back
// depends on gnb_pkg, gnb_front, gnb_queue and gnb_back

// Draws a glyph from a packed 4-bit intensity texture, one byte per input beat,
// high nibble first. Each nibble becomes a 16-bit gray ramp color written at
// origin_x + col + (origin_y + 11 - glyph_baseline + row) * screen_width,
// wrapped to INDEX_BITS and shown on the 21-bit pixel_index port. A byte gives
// two result beats, or one when its high nibble ends an odd-width row; last
// marks a byte's final beat and glyph_done the glyph's final pixel, after
// which the counters are back at zero for the next glyph. The back end puts
// out one pixel a cycle while pop keeps the result side free; a byte passes
// through the queue, the work register and the output register before its
// first pixel shows on the result side. The front keeps taking bytes into a
// two-entry queue while results stall. Configuration writes take effect at
// once, with the cell offset multiply settling in the cycle after; write only
// while no byte is in flight. Width and height of zero act as one and values
// above MAX_GLYPH act as MAX_GLYPH. No start-up pass after reset.
module glyph_nibble_blitter_top #(
    parameter int MAX_GLYPH  = 16,
    parameter int INDEX_BITS = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte side
    input  logic                              push,
    output logic                              full,
    input  logic [gnb_pkg::BYTE_W-1:0]        tex_byte,
    // pixel side
    output logic                              empty,
    input  logic                              pop,
    output logic [gnb_pkg::PIX_W-1:0]         pixel_index,
    output logic [gnb_pkg::COLOR_W-1:0]       pixel_color,
    output logic                              glyph_done,
    output logic                              last,
    // configuration writes
    input  logic                              cfg_write,
    input  logic [gnb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gnb_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import gnb_pkg::*;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int Q_W     = INDEX_BITS + ENTRY_W;

    // configuration registers
    logic [OX_W-1:0]      origin_x_reg;
    logic [OY_W-1:0]      origin_y_reg;
    logic [DIM_W-2:0]     width_reg;
    logic [DIM_W-2:0]     height_reg;
    logic [BL_W-1:0]      baseline_reg;
    logic [SW_W-1:0]      screen_w_reg;

    // framebuffer index of the cell's top line, registered after the multiply
    logic [INDEX_BITS-1:0]      top_reg, top_next;
    logic [INDEX_BITS-1:0]      cell_row;
    logic [INDEX_BITS+SW_W-1:0] top_prod;

    // front to queue
    logic                  f_push;
    entry_t                f_entry;
    logic [INDEX_BITS-1:0] f_base;

    // queue to back
    logic [Q_W-1:0]        q_rd_data;
    logic                  q_full, q_empty, q_pop;
    entry_t                b_entry;
    logic [INDEX_BITS-1:0] b_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            baseline_reg <= RST_BASELINE;
            screen_w_reg <= RST_SCREEN_W;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:       origin_x_reg <= cfg_data[OX_W-1:0];
                REG_ORIGIN_Y:       origin_y_reg <= cfg_data[OY_W-1:0];
                REG_GLYPH_WIDTH:    width_reg    <= cfg_data[DIM_W-2:0];
                REG_GLYPH_HEIGHT:   height_reg   <= cfg_data[DIM_W-2:0];
                REG_GLYPH_BASELINE: baseline_reg <= cfg_data[BL_W-1:0];
                REG_SCREEN_WIDTH:   screen_w_reg <= cfg_data[SW_W-1:0];
                default:            ;
            endcase
        end
    end

    // a baseline above origin_y plus eleven makes the row offset wrap, like the whole index
    assign cell_row = INDEX_BITS'(origin_y_reg) + INDEX_BITS'(ROW_BIAS)
                    - INDEX_BITS'(baseline_reg);
    assign top_prod = cell_row * screen_w_reg;
    assign top_next = top_prod[INDEX_BITS-1:0];

    // reset config puts the cell's top line at index zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_reg <= '0;
        else
            top_reg <= top_next;
    end

    assign full = q_full;

    gnb_front #(
        .MAX_GLYPH  (MAX_GLYPH),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .tex_byte     (tex_byte),
        .q_full       (q_full),
        .glyph_width  (width_reg),
        .glyph_height (height_reg),
        .screen_width (screen_w_reg),
        .q_push       (f_push),
        .q_entry      (f_entry),
        .q_base       (f_base)
    );

    gnb_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data ({f_base, f_entry}),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    assign b_entry = q_rd_data[ENTRY_W-1:0];
    assign b_base  = q_rd_data[Q_W-1:ENTRY_W];

    gnb_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_entry     (b_entry),
        .q_base      (b_base),
        .q_pop       (q_pop),
        .origin_x    (origin_x_reg),
        .top_index   (top_reg),
        .pop         (pop),
        .empty       (empty),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .glyph_done  (glyph_done),
        .last        (last)
    );

`ifndef NO_ASSERTIONS
    // the queue between front and back is never both full and empty
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    // an accepted byte is waiting in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !q_empty)
        else $error("accepted byte missing from queue");

    // the glyph's final pixel is always the final beat of its byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && glyph_done) |-> last)
        else $error("glyph_done on a beat that is not last");

    // the back only draws from a queue that holds something
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");
`endif

endmodule
